>>> design/pem_pkg.sv
// Shared types, constants and the per-level subcube transform of the
// Peano evolvent map. No dependencies.
`default_nettype none

package pem_pkg;

  localparam int NUM_COORDS = 10;
  localparam int IDX_W      = 4;   // coordinate index width
  localparam int SUB_W      = 10;  // subcube number width
  localparam int DIV_W      = 64;  // bits through the prescale divider
  localparam int DIV_STEP   = 8;   // divider bits per stage
  localparam int NUM_DIV    = DIV_W / DIV_STEP;
  localparam int REM_W      = 10;

  localparam logic [63:0] ONE_Q63 = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    MODE_CENTER = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_NODE   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_DIMS   = 2'd0,
    REG_LEVELS = 2'd1,
    REG_MODE   = 2'd2
  } reg_e;

  // Side payload through the divider stages
  typedef struct packed {
    logic [63:0] d_base;
    logic        one;
    logic [62:0] a;
  } pre_t;

  // Word handed from level cell to level cell
  typedef struct packed {
    logic [62:0]      dd;    // digits left, top aligned
    logic [62:0]      frac;
    logic             one;
    logic [IDX_W-1:0] it;
    logic [IDX_W-1:0] k;
    logic [SUB_W-1:0] s;
    logic [SUB_W-1:0] u;     // 1 means +1
    logic [SUB_W-1:0] w;
  } lvl_t;

  typedef struct packed {
    logic [SUB_W-1:0] u;
    logic [SUB_W-1:0] w;
    logic [IDX_W-1:0] it;
    logic [IDX_W-1:0] k;
  } step_t;

  function automatic step_t level_step(input logic [3:0] n, input logic [SUB_W-1:0] s,
                                       input logic [IDX_W-1:0] it,
                                       input logic [IDX_W-1:0] k,
                                       input logic [SUB_W-1:0] w);
    logic [SUB_W-1:0] last_s, sa, c, u, v, u_sw, v_sw;
    logic [IDX_W-1:0] top, axis, k_n;
    logic             dir_pos, dir_neg;
    step_t            r;
    last_s  = SUB_W'((11'd1 << n) - 11'd1);
    top     = n - 4'd1;
    sa      = s << (4'd10 - n);
    for (int i = 0; i < SUB_W; i++) c[i] = sa[SUB_W-1-i];
    u       = '0;
    v       = '0;
    axis    = top;
    dir_pos = 1'b0;
    dir_neg = 1'b0;
    if (s == '0) begin
      u = '0;
      v = '0;
    end else if (s == last_s) begin
      u = SUB_W'(1);
      v = SUB_W'(1) | (SUB_W'(1) << top);
    end else begin
      // axis: highest digit before the last that differs from the last digit
      axis = '0;
      for (int i = 0; i < SUB_W; i++) begin
        u[i] = (i == 0) ? c[0] : (c[i] ^ c[(i == 0) ? 0 : i-1]);
        if (IDX_W'(i) < top && c[i] != s[0]) axis = IDX_W'(i);
      end
      dir_pos = s[0];
      dir_neg = !s[0];
      v = u;
      if (dir_neg) v = v ^ (SUB_W'(1) << axis);
      v = v ^ (SUB_W'(1) << top);
    end
    for (int i = 0; i < SUB_W; i++) begin
      if (i == 0) begin
        u_sw[i] = u[it];
        v_sw[i] = v[it];
      end else if (IDX_W'(i) == it) begin
        u_sw[i] = u[0];
        v_sw[i] = v[0];
      end else begin
        u_sw[i] = u[i];
        v_sw[i] = v[i];
      end
    end
    if (axis == '0) axis = it;
    else if (axis == it) axis = '0;
    if (dir_pos || (!dir_neg && s == '0)) k_n = axis;
    else if (dir_neg) k_n = (it == top) ? '0 : top;
    else k_n = k;
    r.u  = ~(u_sw ^ w);
    r.w  = v_sw ^ w;
    r.it = axis;
    r.k  = k_n;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/peano_evolvent_map.sv
// Peano evolvent map: curve position in, point of the cube out.
// Depends on pem_pkg, pem_prescale and pem_level_cell.
//
// Input stream: one 64-bit word per position x (Q63, 2^63 = 1.0).
// Output stream: ten Q63 signed coordinates in tdata, range error in tuser.
// One word is accepted every cycle unless the output is held; each word passes
// through one input register, eight divider stages of eight bits each, three
// fill stages, one cell per curve level and the output register. Latency is
// the same for every mode. The whole pipeline advances together; when the
// output word is held by the receiver, s_axis_tready_o drops and every stage
// holds its word. Configuration registers are written through cfg_we_i /
// cfg_addr_i / cfg_wdata_i, by the user only while the pipeline is empty;
// the block does not enforce it. Unknown indexes are dropped. Reset empties
// the pipeline and loads dimensions 2, levels 10, center mode.
`default_nettype none

module peano_evolvent_map
  import pem_pkg::*;
#(
  parameter int MAX_DIMS   = 10,
  parameter int MAX_LEVELS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_addr_i,
  input  wire logic [5:0]   cfg_wdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [63:0]  s_axis_tdata_i,   // position
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [639:0]      m_axis_tdata_o,   // coord_0 .. coord_9, 64 bits each
  output logic [0:0]        m_axis_tuser_o    // range_error
);

  logic [3:0] dims_q, dims_d;
  logic [5:0] levels_q, levels_d;
  logic [1:0] mode_q, mode_d;

  always_comb begin
    dims_d   = dims_q;
    levels_d = levels_q;
    mode_d   = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DIMS:   dims_d   = cfg_wdata_i[3:0];
        REG_LEVELS: levels_d = cfg_wdata_i;
        REG_MODE:   mode_d   = cfg_wdata_i[1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q   <= 4'd2;
      levels_q <= 6'd10;
      mode_q   <= MODE_CENTER;
    end else begin
      dims_q   <= dims_d;
      levels_q <= levels_d;
      mode_q   <= mode_d;
    end
  end

  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  logic                      v_c   [MAX_LEVELS+1];
  lvl_t                      lvl_c [MAX_LEVELS+1];
  logic [MAX_DIMS-1:0][63:0] y_c   [MAX_LEVELS+1];

  pem_prescale u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .pos_i   (s_axis_tdata_i),
    .n_i     (dims_q),
    .m_i     (levels_q),
    .mode_i  (mode_q),
    .valid_o (v_c[0]),
    .lvl_o   (lvl_c[0])
  );

  assign y_c[0] = '0;

  for (genvar j = 0; j < MAX_LEVELS; j++) begin : g_lvl
    pem_level_cell #(
      .MAX_DIMS (MAX_DIMS),
      .LEVEL    (j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .n_i     (dims_q),
      .m_i     (levels_q),
      .valid_i (v_c[j]),
      .lvl_i   (lvl_c[j]),
      .y_i     (y_c[j]),
      .valid_o (v_c[j+1]),
      .lvl_o   (lvl_c[j+1]),
      .y_o     (y_c[j+1])
    );
  end

  // Final correction, range check and masking of unused coordinates
  logic [9:0]  nm;
  logic        err;
  logic [63:0] term, half;
  logic        sgn_pos;
  lvl_t        fin;
  logic [NUM_COORDS-1:0][63:0] coord_d;

  assign fin     = lvl_c[MAX_LEVELS];
  assign nm      = 10'(dims_q) * 10'(levels_q);
  assign err     = (dims_q == '0) || ({28'd0, dims_q} > 32'(MAX_DIMS)) ||
                   (levels_q == '0) || ({26'd0, levels_q} > 32'(MAX_LEVELS)) ||
                   (nm > 10'd62);
  assign term    = {1'b0, fin.frac} << (nm - 10'(levels_q));
  assign half    = 64'd1 << (7'd62 - {1'b0, levels_q});
  assign sgn_pos = fin.s != SUB_W'((11'd1 << dims_q) - 11'd1);

  for (genvar i = 0; i < NUM_COORDS; i++) begin : g_out
    if (i < MAX_DIMS) begin : g_used
      always_comb begin
        logic [63:0] y;
        y = y_c[MAX_LEVELS][i];
        if (mode_q == MODE_LINE) begin
          if (fin.k == IDX_W'(i)) y = (fin.u[i] == sgn_pos) ? (y - term) : (y + term);
        end else if (mode_q == MODE_NODE) begin
          y = fin.u[i] ? (y + half) : (y - half);
        end
        coord_d[i] = (err || IDX_W'(i) >= dims_q) ? '0 : y;
      end
    end else begin : g_unused
      assign coord_d[i] = '0;
    end
  end

  logic         out_v_q;
  logic [639:0] out_data_q;
  logic         out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_c[MAX_LEVELS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= coord_d;
      out_err_q  <= err;
    end
  end

  assign m_axis_tvalid_o   = out_v_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_err_q;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("range error word carries nonzero coordinates");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while output word is stalled");

  a_top_unused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && dims_q < 4'(NUM_COORDS)) |-> (m_axis_tdata_o[639:576] == '0))
    else $error("unused coordinate is nonzero");

endmodule

`default_nettype wire

>>> design/pem_div_cell.sv
// One stage of the pipelined restoring divider used by node-mode prescale.
// Depends on pem_pkg.
`default_nettype none

module pem_div_cell
  import pem_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [REM_W-1:0] den_i,
  input  wire logic             valid_i,
  input  wire pre_t             side_i,
  input  wire logic [DIV_W-1:0] nq_i,
  input  wire logic [REM_W-1:0] rem_i,
  output logic                  valid_o,
  output pre_t                  side_o,
  output logic [DIV_W-1:0]      nq_o,
  output logic [REM_W-1:0]      rem_o
);

  logic             valid_q;
  pre_t             side_q;
  logic [DIV_W-1:0] nq_q, nq_d;
  logic [REM_W-1:0] rem_q, rem_d;

  // Shift dividend out of the top, quotient bits in at the bottom
  always_comb begin
    logic [REM_W:0] t;
    logic           ge;
    nq_d  = nq_i;
    rem_d = rem_i;
    for (int b = 0; b < DIV_STEP; b++) begin
      t     = {rem_d, nq_d[DIV_W-1]};
      ge    = t >= {1'b0, den_i};
      nq_d  = {nq_d[DIV_W-2:0], ge};
      rem_d = ge ? REM_W'(t - {1'b0, den_i}) : t[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      nq_q   <= nq_d;
      rem_q  <= rem_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign nq_o    = nq_q;
  assign rem_o   = rem_q;

endmodule

`default_nettype wire

>>> design/pem_prescale.sv
// Input register, mode-dependent position scaling and repeat fill.
// Depends on pem_pkg and pem_div_cell.
`default_nettype none

module pem_prescale
  import pem_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [63:0] pos_i,
  input  wire logic [3:0]  n_i,
  input  wire logic [5:0]  m_i,
  input  wire logic [1:0]  mode_i,
  output logic             valid_o,
  output lvl_t             lvl_o
);

  logic [9:0] nm;
  assign nm = 10'(n_i) * 10'(m_i);

  // Input stage
  pre_t        pre_d, pre_q;
  logic        v0_q;
  logic [63:0] nq0_d, nq0_q;

  always_comb begin
    logic [63:0]  pos_sat, rnd, d1;
    logic [126:0] w_hi, w_lo, diff;
    pos_sat    = (pos_i > ONE_Q63) ? ONE_Q63 : pos_i;
    rnd        = (64'd1 << nm) - 64'd1;
    d1         = pos_sat - ((pos_sat + rnd) >> nm);
    w_hi       = {63'd0, pos_sat} << nm;
    w_lo       = {63'd0, pos_sat} << (nm - 10'(n_i));
    diff       = w_hi - w_lo;
    pre_d.a    = diff[125:63];
    pre_d.one  = pos_i >= ONE_Q63;
    pre_d.d_base = (mode_i == MODE_LINE) ? d1 : pos_sat;
    nq0_d      = (pre_d.a == '0) ? '0 : (64'(pre_d.a) - 64'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
      nq0_q <= nq0_d;
    end
  end

  // Divider chain: floor((a-1) / (2^n-1))
  logic [REM_W-1:0] den;
  assign den = REM_W'((11'd1 << n_i) - 11'd1);

  logic             dv_c   [NUM_DIV+1];
  pre_t             side_c [NUM_DIV+1];
  logic [DIV_W-1:0] nq_c   [NUM_DIV+1];
  logic [REM_W-1:0] rem_c  [NUM_DIV+1];

  assign dv_c[0]   = v0_q;
  assign side_c[0] = pre_q;
  assign nq_c[0]   = nq0_q;
  assign rem_c[0]  = '0;

  for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
    pem_div_cell u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .den_i   (den),
      .valid_i (dv_c[g]),
      .side_i  (side_c[g]),
      .nq_i    (nq_c[g]),
      .rem_i   (rem_c[g]),
      .valid_o (dv_c[g+1]),
      .side_o  (side_c[g+1]),
      .nq_o    (nq_c[g+1]),
      .rem_o   (rem_c[g+1])
    );
  end

  // Fill stages: B/(2^nm-1) is B repeated as a binary fraction
  logic        f1_v_q, f2_v_q, f3_v_q;
  logic [63:0] f1_r_q, f2_r_q, f1_r_d, f2_r_d;
  logic [63:0] f1_db_q, f2_db_q;
  logic        f1_one_q, f2_one_q;
  lvl_t        f3_d, f3_q;
  logic [11:0] sh1, sh2, sh4, sh8, sh16, sh32;

  assign sh1  = 12'(nm);
  assign sh2  = sh1 << 1;
  assign sh4  = sh1 << 2;
  assign sh8  = sh1 << 3;
  assign sh16 = sh1 << 4;
  assign sh32 = sh1 << 5;

  always_comb begin
    logic [63:0] b;
    logic [62:0] a;
    a      = side_c[NUM_DIV].a;
    b      = (a == '0) ? '0 : (64'(a) + nq_c[NUM_DIV]);
    f1_r_d = b << (10'd64 - nm);
  end

  always_comb begin
    logic [63:0] r1, r2;
    r1     = f1_r_q | (f1_r_q >> sh1);
    r2     = r1 | (r1 >> sh2);
    f2_r_d = r2 | (r2 >> sh4);
  end

  always_comb begin
    logic [63:0] r1, r2, r3, dsel, mask;
    r1   = f2_r_q | (f2_r_q >> sh8);
    r2   = r1 | (r1 >> sh16);
    r3   = r2 | (r2 >> sh32);
    dsel = (mode_i == MODE_NODE) ? {1'b0, r3[63:1]} : f2_db_q;
    if (dsel >= ONE_Q63) dsel = ONE_Q63 - 64'd1;
    mask      = (64'd1 << (10'd63 - nm)) - 64'd1;
    f3_d.dd   = dsel[62:0];
    f3_d.frac = f2_one_q ? '0 : (dsel[62:0] & mask[62:0]);
    f3_d.one  = f2_one_q;
    f3_d.it   = '0;
    f3_d.k    = '0;
    f3_d.s    = '0;
    f3_d.u    = '0;
    f3_d.w    = '1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (en_i) begin
      f1_v_q <= dv_c[NUM_DIV];
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_r_q   <= f1_r_d;
      f1_db_q  <= side_c[NUM_DIV].d_base;
      f1_one_q <= side_c[NUM_DIV].one;
      f2_r_q   <= f2_r_d;
      f2_db_q  <= f1_db_q;
      f2_one_q <= f1_one_q;
      f3_q     <= f3_d;
    end
  end

  assign valid_o = f3_v_q;
  assign lvl_o   = f3_q;

endmodule

`default_nettype wire

>>> design/pem_level_cell.sv
// One curve level: picks the subcube digit, updates the rotation state
// and adds +-2^-(level+2) to each coordinate. Depends on pem_pkg.
`default_nettype none

module pem_level_cell
  import pem_pkg::*;
#(
  parameter int MAX_DIMS = 10,
  parameter int LEVEL    = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic [3:0]                 n_i,
  input  wire logic [5:0]                 m_i,
  input  wire logic                       valid_i,
  input  wire lvl_t                       lvl_i,
  input  wire logic [MAX_DIMS-1:0][63:0]  y_i,
  output logic                            valid_o,
  output lvl_t                            lvl_o,
  output logic [MAX_DIMS-1:0][63:0]       y_o
);

  localparam logic [63:0] STEP = 64'd1 << (61 - LEVEL);

  logic                      valid_q;
  lvl_t                      lvl_d, lvl_q;
  logic [MAX_DIMS-1:0][63:0] y_d, y_q;

  always_comb begin
    logic [SUB_W-1:0] last_s, s;
    logic             active;
    step_t            st;
    active = {1'b0, m_i} > 7'(LEVEL);
    last_s = SUB_W'((11'd1 << n_i) - 11'd1);
    s      = lvl_i.one ? last_s : (lvl_i.dd[62:53] >> (4'd10 - n_i));
    st     = level_step(n_i, s, lvl_i.it, lvl_i.k, lvl_i.w);
    lvl_d  = lvl_i;
    y_d    = y_i;
    if (active) begin
      lvl_d.dd = lvl_i.dd << n_i;
      lvl_d.s  = s;
      lvl_d.u  = st.u;
      lvl_d.w  = st.w;
      lvl_d.it = st.it;
      lvl_d.k  = st.k;
      for (int i = 0; i < MAX_DIMS; i++) begin
        y_d[i] = y_i[i] + (st.u[i] ? STEP : (64'd0 - STEP));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lvl_q <= lvl_d;
      y_q   <= y_d;
    end
  end

  assign valid_o = valid_q;
  assign lvl_o   = lvl_q;
  assign y_o     = y_q;

endmodule

`default_nettype wire
